FILE: design/udt_pkg.sv
// udt_pkg: types, constants and digit helpers of the up/down digit timer
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package udt_pkg;

  localparam int unsigned DIGITS = 6;

  typedef logic [DIGITS-1:0][3:0] digits_t;

  typedef enum logic [1:0] {
    CFG_TICKS_PER_SECOND = 2'd0,
    CFG_DOT_TICK         = 2'd1,
    CFG_BLINK_TICK       = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] TPS_RESET   = 8'd200;
  localparam logic [7:0] DOT_RESET   = 8'd100;
  localparam logic [7:0] BLINK_RESET = 8'd150;

  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_ALARM = 8'h5F;
  localparam logic [7:0] SEG_DOT   = 8'h80;

  localparam logic [3:0] STROBE_RESET = 4'b0001;

  // counter digits of the mm:ss value
  localparam logic [DIGITS-1:0] LOW_FOUR = 6'b001111;
  localparam logic [DIGITS-1:0] PAIR0    = 6'b000011;

  localparam digits_t ALARM_RESET = {4'd0, 4'd0, 4'd5, 4'd9, 4'd5, 4'd9};

  typedef struct packed {
    logic [7:0] ticks_per_second;
    logic [7:0] dot_tick;
    logic [7:0] blink_tick;
  } cfg_t;

  typedef struct packed {
    logic [3:0] strobe;
    logic [7:0] pass_count;
    digits_t    shown;
    digits_t    alarm;
    logic       config_latched;
    logic       paused;
    logic       upper_view;
    logic [1:0] edit_field;
  } state_t;

  typedef struct packed {
    logic count_up;
    logic alarm_enable;
    logic run_mode;
    logic show_upper;
    logic button_left;
    logic button_right;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] segments;
    logic [3:0] digit_strobe;
    logic       alarm_hit;
  } out_beat_t;

  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h77;
      4'd1:    s = 8'h41;
      4'd2:    s = 8'h3B;
      4'd3:    s = 8'h6B;
      4'd4:    s = 8'h4D;
      4'd5:    s = 8'h6E;
      4'd6:    s = 8'h7E;
      4'd7:    s = 8'h43;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] digit_limit(input int unsigned k);
    logic [3:0] l;
    if (k == 1 || k == 3) l = 4'd5;
    else l = 4'd9;
    return l;
  endfunction

  // ripple increment over the selected digits, lowest first
  function automatic digits_t inc_digits(input digits_t d, input logic [DIGITS-1:0] sel);
    digits_t    r;
    logic       carry;
    logic [3:0] nd;
    r     = d;
    carry = 1'b1;
    for (int unsigned k = 0; k < DIGITS; k++) begin
      nd = r[k] + 4'd1;
      if (sel[k] && carry) begin
        if (nd > digit_limit(k)) begin
          r[k] = 4'd0;
        end else begin
          r[k]  = nd;
          carry = 1'b0;
        end
      end
    end
    return r;
  endfunction

  function automatic digits_t dec_digits(input digits_t d, input logic [DIGITS-1:0] sel);
    digits_t r;
    logic    borrow;
    r      = d;
    borrow = 1'b1;
    for (int unsigned k = 0; k < DIGITS; k++) begin
      if (sel[k] && borrow) begin
        if (r[k] == 4'd0) begin
          r[k] = digit_limit(k);
        end else begin
          r[k]   = r[k] - 4'd1;
          borrow = 1'b0;
        end
      end
    end
    return r;
  endfunction

endpackage

FILE: design/udt_in_if.sv
// udt_in_if: input channel of the digit timer, one scan pass per beat
// depends on nothing
`timescale 1ns / 1ps

interface udt_in_if;
  logic valid;
  logic ready;
  logic count_up;
  logic alarm_enable;
  logic run_mode;
  logic show_upper;
  logic button_left;
  logic button_right;

  modport source (
    output valid, count_up, alarm_enable, run_mode, show_upper, button_left, button_right,
    input  ready
  );
  modport sink (
    input  valid, count_up, alarm_enable, run_mode, show_upper, button_left, button_right,
    output ready
  );
endinterface

FILE: design/udt_out_if.sv
// udt_out_if: result channel of the digit timer, one display beat per pass
// depends on nothing
`timescale 1ns / 1ps

interface udt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] segments;
  logic [3:0] digit_strobe;
  logic       alarm_hit;

  modport source (
    output valid, segments, digit_strobe, alarm_hit,
    input  ready
  );
  modport sink (
    input  valid, segments, digit_strobe, alarm_hit,
    output ready
  );
endinterface

FILE: design/updown_digit_timer_with_alarm.sv
// updown_digit_timer_with_alarm: mm:ss up/down timer with alarm and display scan
// depends on udt_pkg, udt_in_if, udt_out_if, udt_pass and udt_out_reg
`timescale 1ns / 1ps

// Usage:
//   in_i carries one beat per display scan pass with the switch and button
//   levels. out_o returns one beat per pass: the segment pattern and one-hot
//   strobe of the digit to light, and the alarm hit flag of that pass.
//   cfg_we_i/cfg_idx_i/cfg_data_i write ticks_per_second (0), dot_tick (1)
//   and blink_tick (2); other indexes are ignored. Write only while idle.
// Pass timing:
//   a pass accepted at one edge updates all timer state at that edge and its
//   result is on out_o from the next cycle. One pass is taken every cycle while
//   out_o does not stall; the rate is set by the single result register.
// Reset:
//   rst_ni clears the timer to 00:00, alarm to 59:59, strobe to the lowest
//   digit, configuration registers to 200, 100, 150, and the output to empty.
// Stall:
//   while out_o is stalled with a beat held, in_i.ready is low and no pass is
//   taken; it rises in the cycle out_o.ready does.

module updown_digit_timer_with_alarm (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  udt_in_if.sink     in_i,
  udt_out_if.source  out_o
);

  udt_pkg::cfg_t      cfg_q;
  udt_pkg::state_t    st_q;
  udt_pkg::state_t    st_d;
  udt_pkg::in_beat_t  beat;
  udt_pkg::out_beat_t res_d;
  logic               accept;
  logic               out_ready;

  localparam udt_pkg::state_t ST_RESET = '{
    strobe:         udt_pkg::STROBE_RESET,
    pass_count:     8'd0,
    shown:          '0,
    alarm:          udt_pkg::ALARM_RESET,
    config_latched: 1'b0,
    paused:         1'b0,
    upper_view:     1'b0,
    edit_field:     2'd0
  };

  assign in_i.ready = out_ready;
  assign accept     = in_i.valid && out_ready;

  assign beat.count_up     = in_i.count_up;
  assign beat.alarm_enable = in_i.alarm_enable;
  assign beat.run_mode     = in_i.run_mode;
  assign beat.show_upper   = in_i.show_upper;
  assign beat.button_left  = in_i.button_left;
  assign beat.button_right = in_i.button_right;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_second <= udt_pkg::TPS_RESET;
      cfg_q.dot_tick         <= udt_pkg::DOT_RESET;
      cfg_q.blink_tick       <= udt_pkg::BLINK_RESET;
    end else if (cfg_we_i) begin
      unique case (udt_pkg::cfg_idx_e'(cfg_idx_i))
        udt_pkg::CFG_TICKS_PER_SECOND: cfg_q.ticks_per_second <= cfg_data_i;
        udt_pkg::CFG_DOT_TICK:         cfg_q.dot_tick         <= cfg_data_i;
        udt_pkg::CFG_BLINK_TICK:       cfg_q.blink_tick       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_RESET;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  udt_pass u_pass (
    .st_i   (st_q),
    .cfg_i  (cfg_q),
    .beat_i (beat),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  udt_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .res_i   (res_d),
    .ready_o (out_ready),
    .out_o   (out_o)
  );

endmodule

FILE: design/udt_pass.sv
// udt_pass: next-state and display logic of one scan pass
// depends on udt_pkg
`timescale 1ns / 1ps

module udt_pass (
  input  udt_pkg::state_t    st_i,
  input  udt_pkg::cfg_t      cfg_i,
  input  udt_pkg::in_beat_t  beat_i,
  output udt_pkg::state_t    st_o,
  output udt_pkg::out_beat_t res_o
);

  logic [3:0]             strobe;
  logic [1:0]             pos;
  logic [2:0]             idx;
  logic [7:0]             pc;
  logic [7:0]             seg;
  logic                   hit;
  udt_pkg::digits_t       sd;
  udt_pkg::digits_t       al;
  logic                   cl;
  logic                   uv;
  logic                   paused;
  logic [1:0]             ef;
  logic [2:0]             ef_nx;
  logic [15:0]            want;
  logic [udt_pkg::DIGITS-1:0] pair_sel;

  always_comb begin
    unique case (st_i.strobe)
      4'b0001: strobe = 4'b0010;
      4'b0010: strobe = 4'b0100;
      4'b0100: strobe = 4'b1000;
      default: strobe = udt_pkg::STROBE_RESET;
    endcase

    unique case (strobe)
      4'b0001: pos = 2'd0;
      4'b0010: pos = 2'd1;
      4'b0100: pos = 2'd2;
      default: pos = 2'd3;
    endcase

    pc  = (st_i.pass_count != 8'hFF) ? st_i.pass_count + 8'd1 : st_i.pass_count;
    idx = {1'b0, pos} + (st_i.upper_view ? 3'd2 : 3'd0);
    seg = udt_pkg::seg_code(st_i.shown[idx]);
    if (pc >= cfg_i.dot_tick && strobe == 4'b0100) seg = seg | udt_pkg::SEG_DOT;

    sd     = st_i.shown;
    al     = st_i.alarm;
    cl     = st_i.config_latched;
    uv     = st_i.upper_view;
    paused = st_i.paused;
    ef     = st_i.edit_field;
    hit    = 1'b0;
    ef_nx  = {1'b0, ef} + 3'd1;
    pair_sel = udt_pkg::PAIR0 << {ef, 1'b0};

    // configuration mode entry, blink and alarm view
    if (!beat_i.run_mode) begin
      if (!cl) uv = 1'b0;
      cl = 1'b1;
      if (pc > cfg_i.blink_tick) begin
        if (ef == 2'd0) begin
          if (strobe[0] || strobe[1]) seg = udt_pkg::SEG_BLANK;
        end else begin
          if (strobe[2] || strobe[3]) seg = udt_pkg::SEG_BLANK;
        end
      end else begin
        sd = al;
      end
    end else begin
      if (cl) begin
        cl      = 1'b0;
        sd[3:0] = '0;
      end
      uv = beat_i.show_upper;
    end

    // second boundary
    want = beat_i.count_up ? al[3:0] : '0;
    if (pc >= cfg_i.ticks_per_second) begin
      pc = '0;
      if (beat_i.run_mode && !paused) begin
        if (beat_i.count_up) sd = udt_pkg::inc_digits(sd, udt_pkg::LOW_FOUR);
        else sd = udt_pkg::dec_digits(sd, udt_pkg::LOW_FOUR);
      end
      if (beat_i.alarm_enable && !cl) begin
        if (sd[3:0] == want) begin
          seg = udt_pkg::SEG_ALARM;
          hit = 1'b1;
        end
        if (sd[3:0] >= al[3:0]) sd[3:0] = beat_i.count_up ? '0 : al[3:0];
      end
    end

    // buttons
    if (beat_i.run_mode) begin
      if (beat_i.button_left) paused = ~paused;
      if (beat_i.button_right) begin
        if (!beat_i.count_up && beat_i.alarm_enable) begin
          sd[3:0] = al[3:0];
        end else begin
          paused  = 1'b0;
          sd[3:0] = '0;
        end
      end
    end else if (beat_i.button_left && beat_i.button_right) begin
      if (ef_nx > 3'd2) begin
        ef = 2'd0;
        uv = 1'b0;
      end else begin
        ef = ef_nx[1:0];
        if (ef_nx == 3'd2) uv = 1'b1;
      end
    end else if (ef != 2'd3) begin
      if (beat_i.button_left) al = udt_pkg::dec_digits(al, pair_sel);
      if (beat_i.button_right) al = udt_pkg::inc_digits(al, pair_sel);
    end

    st_o.strobe         = strobe;
    st_o.pass_count     = pc;
    st_o.shown          = sd;
    st_o.alarm          = al;
    st_o.config_latched = cl;
    st_o.paused         = paused;
    st_o.upper_view     = uv;
    st_o.edit_field     = ef;

    res_o.segments     = seg;
    res_o.digit_strobe = strobe;
    res_o.alarm_hit    = hit;
  end

endmodule

FILE: design/udt_out_reg.sv
// udt_out_reg: result register of the digit timer, holds a beat while stalled
// depends on udt_pkg and udt_out_if
`timescale 1ns / 1ps

module udt_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  udt_pkg::out_beat_t res_i,
  output logic               ready_o,
  udt_out_if.source          out_o
);

  logic               valid_q;
  logic               valid_d;
  udt_pkg::out_beat_t res_q;

  assign ready_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (out_o.ready) valid_d = 1'b0;
    if (load_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign out_o.valid        = valid_q;
  assign out_o.segments     = res_q.segments;
  assign out_o.digit_strobe = res_q.digit_strobe;
  assign out_o.alarm_hit    = res_q.alarm_hit;

endmodule

FILE: design/udt_checker.sv
// udt_checker: port-level assertions of the digit timer, bound to the top level
// depends on udt_pkg and updown_digit_timer_with_alarm
`timescale 1ns / 1ps

module udt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_segments,
  input logic [3:0] out_digit_strobe,
  input logic       out_alarm_hit
);

  // held beat stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // an empty result register never blocks a pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // every accepted pass produces a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> out_valid)
    else $error("accepted pass gave no beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> $onehot(out_digit_strobe))
    else $error("digit strobe not one-hot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_alarm_hit |-> out_segments == udt_pkg::SEG_ALARM)
    else $error("alarm hit without alarm pattern");

endmodule

bind updown_digit_timer_with_alarm udt_checker u_udt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid         (in_i.valid),
  .in_ready         (in_i.ready),
  .out_valid        (out_o.valid),
  .out_ready        (out_o.ready),
  .out_segments     (out_o.segments),
  .out_digit_strobe (out_o.digit_strobe),
  .out_alarm_hit    (out_o.alarm_hit)
);

FILE: verif/tb_top.sv
// tb_top: self-checking testbench of the up/down digit timer with alarm
// drives scan passes, predicts every display beat and checks it field by field
// depends on udt_pkg, udt_in_if, udt_out_if and updown_digit_timer_with_alarm
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [9:0][7:0] SEG_TABLE = {8'h6F, 8'h7F, 8'h43, 8'h7E, 8'h6E,
                                           8'h4D, 8'h6B, 8'h3B, 8'h41, 8'h77};

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  udt_pkg::cfg_idx_e cfg_idx;
  logic [7:0]        cfg_data;

  udt_in_if  in_ch ();
  udt_out_if out_ch ();

  updown_digit_timer_with_alarm uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // timer model state and registers
  logic [3:0]       m_strobe;
  logic [7:0]       m_pass;
  udt_pkg::digits_t m_shown;
  udt_pkg::digits_t m_alarm;
  logic             m_latched;
  logic             m_paused;
  logic             m_upper;
  logic [1:0]       m_field;
  logic [7:0]       m_tps;
  logic [7:0]       m_dot;
  logic [7:0]       m_blink;

  udt_pkg::out_beat_t disp_expected[$];
  udt_pkg::out_beat_t mon_want;
  int unsigned        errors;
  int unsigned        passes_sent;
  int unsigned        beats_checked;
  int unsigned        hits_seen;
  int unsigned        reg_writes;
  int unsigned        cycle_cnt;
  int unsigned        hold_left;
  logic               in_gaps_on;
  logic               out_gaps_on;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t timeout with %0d beats outstanding", $time, disp_expected.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [3:0] digit_top(input int unsigned k);
    return (k == 1 || k == 3) ? 4'd5 : 4'd9;
  endfunction

  function automatic udt_pkg::digits_t step_up(input udt_pkg::digits_t d,
                                               input int unsigned first,
                                               input int unsigned n);
    udt_pkg::digits_t r;
    logic             carry;
    r     = d;
    carry = 1'b1;
    for (int unsigned k = first; k < first + n; k++) begin
      if (carry) begin
        r[k] = r[k] + 4'd1;
        if (r[k] > digit_top(k)) r[k] = 4'd0;
        else carry = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic udt_pkg::digits_t step_down(input udt_pkg::digits_t d,
                                                 input int unsigned first,
                                                 input int unsigned n);
    udt_pkg::digits_t r;
    logic             borrow;
    r      = d;
    borrow = 1'b1;
    for (int unsigned k = first; k < first + n; k++) begin
      if (borrow) begin
        if (r[k] == 4'd0) begin
          r[k] = digit_top(k);
        end else begin
          r[k]   = r[k] - 4'd1;
          borrow = 1'b0;
        end
      end
    end
    return r;
  endfunction

  task automatic reset_timer_model();
    m_strobe  = udt_pkg::STROBE_RESET;
    m_pass    = 8'd0;
    m_shown   = '0;
    m_alarm   = udt_pkg::ALARM_RESET;
    m_latched = 1'b0;
    m_paused  = 1'b0;
    m_upper   = 1'b0;
    m_field   = 2'd0;
    m_tps     = udt_pkg::TPS_RESET;
    m_dot     = udt_pkg::DOT_RESET;
    m_blink   = udt_pkg::BLINK_RESET;
  endtask

  // one scan pass of the timer: display, second tick, alarm, buttons
  task automatic predict_scan(input udt_pkg::in_beat_t s);
    udt_pkg::out_beat_t r;
    int unsigned        pos;
    int unsigned        idx;
    logic [3:0]         d;
    logic [7:0]         seg;
    logic               hit;
    logic               match;
    logic               reach;
    logic               decided;
    case (m_strobe)
      4'b0001: begin m_strobe = 4'b0010; pos = 1; end
      4'b0010: begin m_strobe = 4'b0100; pos = 2; end
      4'b0100: begin m_strobe = 4'b1000; pos = 3; end
      default: begin m_strobe = 4'b0001; pos = 0; end
    endcase
    if (m_pass != 8'hFF) m_pass = m_pass + 8'd1;
    idx = pos + (m_upper ? 2 : 0);
    d   = m_shown[idx];
    seg = (d <= 4'd9) ? SEG_TABLE[d] : udt_pkg::SEG_BLANK;
    if (m_pass >= m_dot && m_strobe == 4'b0100) seg = seg | udt_pkg::SEG_DOT;

    if (!s.run_mode) begin
      if (!m_latched) begin
        m_latched = 1'b1;
        m_upper   = 1'b0;
      end
      if (m_pass > m_blink) begin
        if (m_field == 2'd0) begin
          if (m_strobe < 4'd4) seg = udt_pkg::SEG_BLANK;
        end else if (m_strobe >= 4'd4) begin
          seg = udt_pkg::SEG_BLANK;
        end
      end else begin
        m_shown = m_alarm;
      end
    end else begin
      if (m_latched) begin
        m_latched = 1'b0;
        for (int k = 0; k < 4; k++) m_shown[k] = 4'd0;
      end
      m_upper = s.show_upper;
    end

    hit = 1'b0;
    if (m_pass >= m_tps) begin
      m_pass = 8'd0;
      if (s.run_mode && !m_paused) begin
        m_shown = s.count_up ? step_up(m_shown, 0, 4) : step_down(m_shown, 0, 4);
      end
      if (s.alarm_enable && !m_latched) begin
        match = 1'b1;
        for (int k = 0; k < 4; k++) begin
          if (m_shown[k] != (s.count_up ? m_alarm[k] : 4'd0)) match = 1'b0;
        end
        if (match) begin
          seg = udt_pkg::SEG_ALARM;
          hit = 1'b1;
        end
        reach   = 1'b0;
        decided = 1'b0;
        for (int k = 3; k >= 0; k--) begin
          if (!decided) begin
            if (m_shown[k] > m_alarm[k]) begin
              reach   = 1'b1;
              decided = 1'b1;
            end else if (m_shown[k] < m_alarm[k]) begin
              decided = 1'b1;
            end
          end
        end
        if (!decided) reach = 1'b1;
        if (reach) begin
          for (int k = 0; k < 4; k++) m_shown[k] = s.count_up ? 4'd0 : m_alarm[k];
        end
      end
    end

    if (s.run_mode) begin
      if (s.button_left) m_paused = ~m_paused;
      if (s.button_right) begin
        if (!s.count_up && s.alarm_enable) begin
          for (int k = 0; k < 4; k++) m_shown[k] = m_alarm[k];
        end else begin
          m_paused = 1'b0;
          for (int k = 0; k < 4; k++) m_shown[k] = 4'd0;
        end
      end
    end else if (s.button_left && s.button_right) begin
      if (m_field >= 2'd2) begin
        m_field = 2'd0;
        m_upper = 1'b0;
      end else begin
        m_field = m_field + 2'd1;
        if (m_field == 2'd2) m_upper = 1'b1;
      end
    end else if (m_field <= 2'd2) begin
      if (s.button_left) m_alarm = step_down(m_alarm, 2 * m_field, 2);
      if (s.button_right) m_alarm = step_up(m_alarm, 2 * m_field, 2);
    end

    r.segments     = seg;
    r.digit_strobe = m_strobe;
    r.alarm_hit    = hit;
    disp_expected.push_back(r);
  endtask

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_scan(input udt_pkg::in_beat_t s);
    int unsigned gap;
    gap = in_gaps_on ? gap_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.count_up     = s.count_up;
    in_ch.alarm_enable = s.alarm_enable;
    in_ch.run_mode     = s.run_mode;
    in_ch.show_upper   = s.show_upper;
    in_ch.button_left  = s.button_left;
    in_ch.button_right = s.button_right;
    in_ch.valid        = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_scan(s);
    passes_sent++;
  endtask

  task automatic send_fields(input logic up, input logic alarm, input logic run,
                             input logic upper, input logic left, input logic right);
    udt_pkg::in_beat_t s;
    s.count_up     = up;
    s.alarm_enable = alarm;
    s.run_mode     = run;
    s.show_upper   = upper;
    s.button_left  = left;
    s.button_right = right;
    send_scan(s);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (disp_expected.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input udt_pkg::cfg_idx_e idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      udt_pkg::CFG_TICKS_PER_SECOND: m_tps   = val;
      udt_pkg::CFG_DOT_TICK:         m_dot   = val;
      udt_pkg::CFG_BLINK_TICK:       m_blink = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_timing(input logic [7:0] tps, input logic [7:0] dot,
                            input logic [7:0] blink);
    wait_drained();
    write_reg(udt_pkg::CFG_TICKS_PER_SECOND, tps);
    write_reg(udt_pkg::CFG_DOT_TICK, dot);
    write_reg(udt_pkg::CFG_BLINK_TICK, blink);
  endtask

  task automatic flag_mismatch(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    errors++;
    $display("%0t mismatch on %s: expected %h actual %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (disp_expected.size() == 0) begin
        flag_mismatch("unexpected beat", 8'h00, out_ch.segments);
      end else begin
        mon_want = disp_expected.pop_front();
        beats_checked++;
        if (out_ch.segments !== mon_want.segments) begin
          flag_mismatch("segments", mon_want.segments, out_ch.segments);
        end
        if (out_ch.digit_strobe !== mon_want.digit_strobe) begin
          flag_mismatch("digit_strobe", mon_want.digit_strobe, out_ch.digit_strobe);
        end
        if (out_ch.alarm_hit !== mon_want.alarm_hit) begin
          flag_mismatch("alarm_hit", mon_want.alarm_hit, out_ch.alarm_hit);
        end
        if (mon_want.alarm_hit) hits_seen++;
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        if (out_gaps_on && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  // strobe rotation and digit view with the reset timing
  task automatic test_scan_after_reset();
    send_fields(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_fields(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_fields(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_fields(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
  endtask

  // pause toggle and counter clear in run mode, with timings 2, 1 and 1
  task automatic test_run_buttons();
    set_timing(8'd2, 8'd1, 8'd1);
    send_fields(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_fields(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    send_fields(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_fields(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_fields(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    send_fields(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
  endtask

  // count up one second, then down to zero for a hit, then load the alarm
  task automatic test_down_count_alarm();
    send_fields(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_fields(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_fields(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_fields(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_fields(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
  endtask

  // alarm editing: wrap of the seconds and minutes pairs, a step of the top pair and the field walk back to zero
  task automatic test_alarm_edit();
    send_fields(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
    send_fields(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
    send_fields(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
    send_fields(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
    send_fields(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
    send_fields(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1);
    send_fields(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
    send_fields(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  // tick counts of one and zero make every pass a second
  task automatic test_tiny_second();
    set_timing(8'd1, 8'd1, 8'd1);
    send_fields(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_fields(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    wait_drained();
    write_reg(udt_pkg::CFG_TICKS_PER_SECOND, 8'd0);
    send_fields(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_fields(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
  endtask

  // all registers at the top: the second falls as the pass count reaches 255, then configuration mode
  task automatic test_register_extremes();
    set_timing(8'd255, 8'd255, 8'd255);
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    repeat (262) send_fields(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    repeat (6) send_fields(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_output_backpressure();
    set_timing(8'd4, 8'd2, 8'd3);
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    @(posedge clk);
    hold_left = 150;
    repeat (20) send_fields(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
  endtask

  // sessions of steady switches with occasional button presses and noise
  task automatic test_random_sessions(input int unsigned n_items);
    int unsigned       sent;
    int unsigned       len;
    int unsigned       tps;
    logic              first;
    udt_pkg::in_beat_t s;
    udt_pkg::in_beat_t sw;
    sent  = 0;
    first = 1'b1;
    while (sent < n_items) begin
      if (first || $urandom_range(0, 4) == 0) begin
        tps = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 255) : $urandom_range(2, 10);
        set_timing(tps[7:0], 8'($urandom_range(1, tps)), 8'($urandom_range(1, tps)));
        first = 1'b0;
      end
      sw.count_up     = $urandom_range(0, 1);
      sw.alarm_enable = ($urandom_range(0, 3) != 0);
      sw.run_mode     = ($urandom_range(0, 3) != 0);
      sw.show_upper   = $urandom_range(0, 1);
      in_gaps_on      = ($urandom_range(0, 3) != 0);
      out_gaps_on     = ($urandom_range(0, 3) != 0);
      len             = $urandom_range(8, 60);
      repeat (len) begin
        s = sw;
        if (sw.run_mode) begin
          s.button_left  = ($urandom_range(0, 59) == 0);
          s.button_right = ($urandom_range(0, 79) == 0);
        end else begin
          s.button_left  = ($urandom_range(0, 3) == 0);
          s.button_right = ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 24) == 0) s = udt_pkg::in_beat_t'($urandom_range(0, 63));
        send_scan(s);
        sent++;
      end
    end
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.count_up     = 1'b0;
    in_ch.alarm_enable = 1'b0;
    in_ch.run_mode     = 1'b0;
    in_ch.show_upper   = 1'b0;
    in_ch.button_left  = 1'b0;
    in_ch.button_right = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = udt_pkg::CFG_TICKS_PER_SECOND;
    cfg_data           = 8'd0;
    errors             = 0;
    passes_sent        = 0;
    beats_checked      = 0;
    hits_seen          = 0;
    reg_writes         = 0;
    cycle_cnt          = 0;
    hold_left          = 0;
    in_gaps_on         = 1'b1;
    out_gaps_on        = 1'b1;
    rst_n              = 1'b0;
    reset_timer_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_scan_after_reset();
    test_run_buttons();
    test_down_count_alarm();
    test_alarm_edit();
    test_tiny_second();
    test_register_extremes();
    test_output_backpressure();
    test_random_sessions(640);

    wait_drained();
    repeat (4) @(posedge clk);
    $display("run covered %0d scan passes and %0d checked display beats", passes_sent,
             beats_checked);
    $display("with %0d alarm hits and %0d register writes", hits_seen, reg_writes);
    if (errors == 0 && disp_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
